>>> hdl/ssd_pkg.sv
// Shared types, constants and character encoding for the seven-segment scan driver.
// No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

	localparam int DigitsDefault = 4;
	localparam int QueueDepth    = 2;
	localparam int PosW          = 2;
	localparam int FrameW        = 16;
	localparam int CharW         = 8;
	localparam int NumChars      = 4;
	localparam int TimeW         = 32;
	localparam int PeriodW       = 16;

	localparam logic [PeriodW-1:0] RefreshReset = 16'd2;
	localparam logic [CharW-1:0]   CharSpace    = 8'h20;
	localparam logic [CharW-1:0]   CharNul      = 8'h00;
	localparam logic [CharW-1:0]   CaseOffset   = 8'h20;

	localparam logic [7:0] Sel0 = 8'hF1;
	localparam logic [7:0] Sel1 = 8'hF2;
	localparam logic [7:0] Sel2 = 8'hF4;
	localparam logic [7:0] Sel3 = 8'hF8;

	typedef struct packed {
		logic [FrameW-1:0] bits;
		logic [PosW-1:0]   pos;
	} frame_t;

	function automatic logic [7:0] sel_code(input logic [PosW-1:0] p);
		logic [7:0] r;
		case (p)
			2'd0:    r = Sel0;
			2'd1:    r = Sel1;
			2'd2:    r = Sel2;
			2'd3:    r = Sel3;
			default: r = Sel0;
		endcase
		return r;
	endfunction

	// segment byte, bit 0 = a ... bit 6 = g, active high
	function automatic logic [7:0] glyph_of(input logic [CharW-1:0] c_in);
		logic [CharW-1:0] c;
		logic [7:0]       g;
		c = (c_in inside {[8'h61:8'h7A]}) ? c_in - CaseOffset : c_in;
		case (c)
			8'h30, 8'h4F: g = 8'h3F; // 0 O
			8'h31, 8'h49: g = 8'h06; // 1 I
			8'h32, 8'h5A: g = 8'h5B; // 2 Z
			8'h33:        g = 8'h4F;
			8'h34:        g = 8'h66;
			8'h35, 8'h53: g = 8'h6D; // 5 S
			8'h36:        g = 8'h7D;
			8'h37:        g = 8'h07;
			8'h38, 8'h42: g = 8'h7F; // 8 B
			8'h39:        g = 8'h6F;
			8'h41:        g = 8'h77; // A
			8'h43:        g = 8'h39; // C
			8'h44:        g = 8'h5E; // D
			8'h45:        g = 8'h79; // E
			8'h46:        g = 8'h71; // F
			8'h48:        g = 8'h76; // H
			8'h4C:        g = 8'h38; // L
			8'h4E:        g = 8'h54; // N
			8'h50:        g = 8'h73; // P
			8'h52:        g = 8'h50; // R
			8'h54:        g = 8'h78; // T
			8'h55:        g = 8'h3E; // U
			8'h2D:        g = 8'h40; // -
			8'h5F:        g = 8'h08; // _
			default:      g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

>>> hdl/ssd_front.sv
// Front end: accepts requests, holds text, timing and scan state, builds frames.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_front #(
	parameter int DIGITS = ssd_pkg::DigitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ssd_pkg::PeriodW-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_cmd,
	input  logic [63:0]                 in_data,
	output logic                        push,
	output ssd_pkg::frame_t             push_frame,
	input  logic                        q_full
);

	logic [ssd_pkg::CharW-1:0]   text_q [ssd_pkg::NumChars];
	logic [ssd_pkg::PosW-1:0]    pos_q;
	logic [ssd_pkg::TimeW-1:0]   last_q;
	logic [ssd_pkg::PeriodW-1:0] period_q;

	logic                        acc;
	logic [ssd_pkg::TimeW-1:0]   now_ms;
	logic [ssd_pkg::TimeW-1:0]   elapsed;
	logic                        due;
	logic [ssd_pkg::CharW-1:0]   chr [ssd_pkg::NumChars];
	logic [ssd_pkg::NumChars-1:0] ended;
	logic [ssd_pkg::PosW-1:0]    pos_nxt;

	localparam logic [ssd_pkg::PosW-1:0] LastPos = ssd_pkg::PosW'(DIGITS - 1);

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign now_ms   = in_data[31:0];
	assign elapsed  = now_ms - last_q;
	assign due      = elapsed >= {{(ssd_pkg::TimeW-ssd_pkg::PeriodW){1'b0}}, period_q};
	assign push     = acc && !in_cmd && due;
	assign pos_nxt  = (pos_q == LastPos) ? '0 : pos_q + 1'b1;

	always_comb begin
		for (int k = 0; k < ssd_pkg::NumChars; k++) begin
			chr[k] = in_data[32 + 8*k +: 8];
		end
		// a NUL blanks itself and everything after it
		ended[0] = (chr[0] == ssd_pkg::CharNul);
		for (int k = 1; k < ssd_pkg::NumChars; k++) begin
			ended[k] = ended[k-1] || (chr[k] == ssd_pkg::CharNul);
		end
		push_frame.bits = {~ssd_pkg::glyph_of(text_q[pos_q]), ssd_pkg::sel_code(pos_q)};
		push_frame.pos  = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ssd_pkg::NumChars; k++) begin
				text_q[k] <= ssd_pkg::CharSpace;
			end
			pos_q    <= '0;
			last_q   <= '0;
			period_q <= ssd_pkg::RefreshReset;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (acc && in_cmd) begin
				for (int k = 0; k < ssd_pkg::NumChars; k++) begin
					text_q[k] <= ended[k] ? ssd_pkg::CharSpace : chr[k];
				end
			end
			if (push) begin
				last_q <= now_ms;
				pos_q  <= pos_nxt;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (last_q == $past(now_ms)))
		else $error("refresh time not taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_cmd) |=> $stable(pos_q) && $stable(last_q))
		else $error("text request disturbed scan state");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LastPos)
		else $error("scan position out of range");

endmodule

>>> hdl/ssd_fifo.sv
// Short frame queue between front and back ends, flip-flop storage.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssd_pkg::frame_t wr_frame,
	output logic            full,
	input  logic            pop,
	output logic            rd_valid,
	output ssd_pkg::frame_t rd_frame
);

	localparam int Depth = ssd_pkg::QueueDepth;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);
	localparam logic [CntW-1:0] DepthC = CntW'(Depth);
	localparam logic [PtrW-1:0] LastP  = PtrW'(Depth - 1);

	ssd_pkg::frame_t  mem_q [Depth];
	logic [PtrW-1:0]  wp_q;
	logic [PtrW-1:0]  rp_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_pop;

	assign full     = (cnt_q == DepthC);
	assign rd_valid = (cnt_q != '0);
	assign rd_frame = mem_q[rp_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LastP) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == LastP) ? '0 : rp_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DepthC)
		else $error("queue count overflow");

endmodule

>>> hdl/ssd_back.sv
// Back end: shifts each queued frame out one bit per request, MSB first.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  ssd_pkg::frame_t          q_frame,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_bit,
	output logic [ssd_pkg::PosW-1:0] out_pos,
	output logic                     out_last
);

	localparam int CntW = $clog2(ssd_pkg::FrameW);
	localparam logic [CntW-1:0] LastBit = CntW'(ssd_pkg::FrameW - 1);

	logic [ssd_pkg::FrameW-1:0] shift_q;
	logic [ssd_pkg::PosW-1:0]   pos_q;
	logic [CntW-1:0]            cnt_q;
	logic                       valid_q;
	logic                       fire;

	assign out_valid = valid_q;
	assign out_bit   = shift_q[ssd_pkg::FrameW-1];
	assign out_pos   = pos_q;
	assign out_last  = (cnt_q == LastBit);
	assign fire      = valid_q && out_ready;
	assign pop       = q_valid && (!valid_q || (fire && out_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= q_frame.bits;
			pos_q   <= q_frame.pos;
		end else if (fire) begin
			shift_q <= {shift_q[ssd_pkg::FrameW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				cnt_q   <= '0;
			end else if (fire) begin
				if (out_last) begin
					valid_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && out_last && !q_valid) |=> !out_valid)
		else $error("frame end not released");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !out_last) |=> (out_pos == $past(out_pos)) && out_valid)
		else $error("digit changed inside frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (cnt_q == '0) && out_valid)
		else $error("frame load failed");

endmodule

>>> hdl/seven_segment_scan_driver.sv
// A tick's sixteen-bit refresh frame is queued, then loaded into the bit shifter.
// Throughput: one bit per cycle while m_tready is high, set by the bit shifter;
// the input takes a request every cycle while the two-frame queue has room.
// Set-text and early ticks produce no output. Reset (arst_n, async) blanks the text
// to spaces, zeroes scan position and last refresh time, and sets the period to 2 ms.
`timescale 1ns / 1ps

module seven_segment_scan_driver #(
	parameter int DIGITS = ssd_pkg::DigitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ssd_pkg::PeriodW-1:0] cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,  // now_ms[31:0], char0..char3
	input  logic                        s_tuser,  // command
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,  // serial_bit, digit_index[2:1], zeros
	output logic                        m_tlast   // frame_last
);

	logic                      push;
	ssd_pkg::frame_t           push_frame;
	logic                      q_full;
	logic                      pop;
	logic                      q_valid;
	ssd_pkg::frame_t           q_frame;
	logic                      out_bit;
	logic [ssd_pkg::PosW-1:0]  out_pos;

	ssd_front #(.DIGITS(DIGITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_data    (s_tdata),
		.push       (push),
		.push_frame (push_frame),
		.q_full     (q_full)
	);

	ssd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_frame (push_frame),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_frame (q_frame)
	);

	ssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_frame   (q_frame),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bit   (out_bit),
		.out_pos   (out_pos),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'b0, out_pos, out_bit};

endmodule
